>>> hw/rtl/tfc_pkg.sv
// Package for the two-level FIFO cache: sizes, codes, controller states
// and the command/status structs passed between controller and datapath.
// No dependencies.
package tfc_pkg;

	localparam int FLE_DEF  = 64;
	localparam int SLE_DEF  = 128;
	localparam int MW_DEF   = 256;
	localparam int ADDR_W   = 8;
	localparam int DATA_W   = 32;
	localparam int LVL_W    = 2;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic POL_WT = 1'b0;
	localparam logic POL_WB = 1'b1;

	localparam logic [LVL_W-1:0] LVL_L1   = 2'd0;
	localparam logic [LVL_W-1:0] LVL_L2   = 2'd1;
	localparam logic [LVL_W-1:0] LVL_MISS = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_READ,
		ST_EXEC,
		ST_WB,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic lookup;
		logic rd;
		logic exec;
		logic wb;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic need_wb;
	} sts_t;

endpackage

>>> hw/rtl/tfc_ram.sv
// Generic one-write, one-read RAM with registered read data.
// No dependencies.
module tfc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

>>> hw/rtl/tfc_ctrl.sv
// Controller state machine for the two-level FIFO cache.
// Depends on tfc_pkg.
module tfc_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  tfc_pkg::sts_t sts,
	output tfc_pkg::cmd_t cmd
);
	import tfc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (sts.clr_last) state_d = ST_IDLE;
			ST_IDLE:   if (in_valid) state_d = ST_LOOKUP;
			ST_LOOKUP: state_d = ST_READ;
			ST_READ:   state_d = ST_EXEC;
			ST_EXEC:   state_d = sts.need_wb ? ST_WB : ST_RESP;
			ST_WB:     state_d = ST_RESP;
			ST_RESP:   if (out_ready) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		out_valid  = (state_q == ST_RESP);
		cmd.clr    = (state_q == ST_CLEAR);
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.lookup = (state_q == ST_LOOKUP);
		cmd.rd     = (state_q == ST_READ);
		cmd.exec   = (state_q == ST_EXEC);
		cmd.wb     = (state_q == ST_WB);
	end
endmodule

>>> hw/rtl/tfc_dp.sv
// Datapath: tag/valid/dirty registers with parallel compare, ring pointers,
// data RAMs for both levels and the backing memory. Depends on tfc_pkg, tfc_ram.
module tfc_dp #(
	parameter int N1 = tfc_pkg::FLE_DEF,
	parameter int N2 = tfc_pkg::SLE_DEF,
	parameter int MW = tfc_pkg::MW_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tfc_pkg::cmd_t                     cmd,
	output tfc_pkg::sts_t                     sts,
	input  logic                              cfg_we,
	input  logic                              cfg_policy,
	input  logic                              operation,
	input  logic [tfc_pkg::ADDR_W-1:0]        address,
	input  logic signed [tfc_pkg::DATA_W-1:0] write_data,
	output logic signed [tfc_pkg::DATA_W-1:0] read_data,
	output logic [tfc_pkg::LVL_W-1:0]         hit_level
);
	import tfc_pkg::*;

	localparam int I1W = $clog2(N1);
	localparam int I2W = $clog2(N2);
	localparam int C1W = $clog2(N1 + 1);
	localparam int C2W = $clog2(N2 + 1);
	localparam int MAW = $clog2(MW);

	logic              policy_q;
	logic              op_q;
	logic [ADDR_W-1:0] tag_q;
	logic [DATA_W-1:0] wdata_q;
	logic [ADDR_W-1:0] red;
	logic [31:0]       rem;
	logic [MAW-1:0]    maddr;
	logic [MAW-1:0]    clr_q;

	logic [ADDR_W-1:0] tag1_q [N1];
	logic [N1-1:0]     val1_q, dirty1_q, m1_q;
	logic [ADDR_W-1:0] tag2_q [N2];
	logic [N2-1:0]     val2_q, dirty2_q, m2_q;
	logic [C1W-1:0]    cnt1_q;
	logic [C2W-1:0]    cnt2_q;
	logic [I1W-1:0]    head1_q, idx1, idx1_q, slot1, l1_raddr, l1_waddr;
	logic [I2W-1:0]    head2_q, idx2, idx2_q, slot2, l2_raddr, l2_waddr;
	logic              hit1_q, hit2_q, full1, full2, miss, evict, fill_dirty;
	logic [ADDR_W-1:0] wb_tag_q;
	logic [DATA_W-1:0] l1_rd, l2_rd, mem_rd, fill_val, l2_wdata, mem_wdata;
	logic              l1_we, l2_we, mem_we;
	logic [MAW-1:0]    mem_waddr;

	// address mod MW by restoring subtraction, one quotient bit per step
	always_comb begin
		rem = 32'(address);
		for (int k = ADDR_W - 1; k >= 0; k--) begin
			if (rem >= (32'(MW) << k)) begin
				rem = rem - (32'(MW) << k);
			end
		end
		red = rem[ADDR_W-1:0];
	end

	assign maddr = MAW'(tag_q);
	assign full1 = (cnt1_q == C1W'(N1));
	assign full2 = (cnt2_q == C2W'(N2));
	assign slot1 = cnt1_q[I1W-1:0];
	assign slot2 = cnt2_q[I2W-1:0];
	assign miss  = !hit1_q && !hit2_q;
	assign evict = miss && full1 && full2;
	assign fill_dirty = (op_q == OP_WRITE) && (policy_q == POL_WB);

	assign sts.clr_last = (clr_q == MAW'(MW - 1));
	assign sts.need_wb  = evict && dirty2_q[head2_q];

	// hit index: tags are unique, so an OR of matching indices is enough
	always_comb begin
		idx1 = '0;
		for (int i = 0; i < N1; i++) begin
			if (m1_q[i]) idx1 = idx1 | I1W'(i);
		end
		idx2 = '0;
		for (int i = 0; i < N2; i++) begin
			if (m2_q[i]) idx2 = idx2 | I2W'(i);
		end
	end

	assign l1_raddr = (|m1_q) ? idx1 : head1_q;
	assign l2_raddr = (|m2_q) ? idx2 : head2_q;

	assign fill_val = (op_q == OP_WRITE) ? wdata_q : mem_rd;
	assign l1_we = cmd.exec && (((op_q == OP_WRITE) && hit1_q) || (miss && (!full1 || full2)));
	assign l1_waddr = hit1_q ? idx1_q : (!full1 ? slot1 : head1_q);
	assign l2_we = cmd.exec && (((op_q == OP_WRITE) && !hit1_q && hit2_q) || (miss && full1));
	assign l2_waddr = hit2_q ? idx2_q : (!full2 ? slot2 : head2_q);
	assign l2_wdata = evict ? l1_rd : fill_val;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = maddr;
		mem_wdata = wdata_q;
		if (cmd.clr) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (cmd.wb) begin
			mem_we    = 1'b1;
			mem_waddr = MAW'(wb_tag_q);
			mem_wdata = l2_rd;
		end else if (cmd.exec && (op_q == OP_WRITE) && (policy_q == POL_WT)) begin
			mem_we = 1'b1;
		end
	end

	tfc_ram #(.WIDTH(DATA_W), .DEPTH(N1)) u_l1 (
		.clk(clk), .we(l1_we), .waddr(l1_waddr), .wdata(fill_val),
		.re(cmd.rd), .raddr(l1_raddr), .rdata(l1_rd)
	);

	tfc_ram #(.WIDTH(DATA_W), .DEPTH(N2)) u_l2 (
		.clk(clk), .we(l2_we), .waddr(l2_waddr), .wdata(l2_wdata),
		.re(cmd.rd), .raddr(l2_raddr), .rdata(l2_rd)
	);

	tfc_ram #(.WIDTH(DATA_W), .DEPTH(MW)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.re(cmd.rd), .raddr(maddr), .rdata(mem_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_WB;
			clr_q    <= '0;
			val1_q   <= '0;
			dirty1_q <= '0;
			val2_q   <= '0;
			dirty2_q <= '0;
			cnt1_q   <= '0;
			cnt2_q   <= '0;
			head1_q  <= '0;
			head2_q  <= '0;
		end else begin
			if (cfg_we) policy_q <= cfg_policy;
			if (cmd.clr) clr_q <= clr_q + 1'b1;
			if (cmd.exec) begin
				if (hit1_q) begin
					if (op_q == OP_WRITE && policy_q == POL_WB) dirty1_q[idx1_q] <= 1'b1;
				end else if (hit2_q) begin
					if (op_q == OP_WRITE && policy_q == POL_WB) dirty2_q[idx2_q] <= 1'b1;
				end else if (!full1) begin
					val1_q[slot1]   <= 1'b1;
					dirty1_q[slot1] <= fill_dirty;
					cnt1_q          <= cnt1_q + 1'b1;
				end else if (!full2) begin
					val2_q[slot2]   <= 1'b1;
					dirty2_q[slot2] <= fill_dirty;
					cnt2_q          <= cnt2_q + 1'b1;
				end else begin
					// oldest L1 entry moves into the slot of the evicted L2 entry
					dirty2_q[head2_q] <= dirty1_q[head1_q];
					dirty1_q[head1_q] <= fill_dirty;
					head1_q <= (head1_q == I1W'(N1 - 1)) ? '0 : head1_q + 1'b1;
					head2_q <= (head2_q == I2W'(N2 - 1)) ? '0 : head2_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= operation;
			tag_q   <= red;
			wdata_q <= write_data;
		end
		if (cmd.lookup) begin
			for (int i = 0; i < N1; i++) m1_q[i] <= val1_q[i] && (tag1_q[i] == tag_q);
			for (int i = 0; i < N2; i++) m2_q[i] <= val2_q[i] && (tag2_q[i] == tag_q);
		end
		if (cmd.rd) begin
			hit1_q <= |m1_q;
			hit2_q <= !(|m1_q) && (|m2_q);
			idx1_q <= idx1;
			idx2_q <= idx2;
		end
		if (cmd.exec) begin
			wb_tag_q <= tag2_q[head2_q];
			if (miss) begin
				if (!full1) begin
					tag1_q[slot1] <= tag_q;
				end else if (!full2) begin
					tag2_q[slot2] <= tag_q;
				end else begin
					tag2_q[head2_q] <= tag1_q[head1_q];
					tag1_q[head1_q] <= tag_q;
				end
			end
			hit_level <= hit1_q ? LVL_L1 : (hit2_q ? LVL_L2 : LVL_MISS);
			if (op_q == OP_WRITE) begin
				read_data <= '0;
			end else begin
				read_data <= hit1_q ? l1_rd : (hit2_q ? l2_rd : mem_rd);
			end
		end
	end
endmodule

>>> hw/rtl/two_level_fifo_cache_top.sv
// Two-level fully associative FIFO cache in front of a word memory.
// Each request passes through lookup, read and execute states, plus a write-back
// state when a dirty L2 victim is evicted, before the result is shown; one request
// at a time, the next taken the cycle after the result is accepted.
// Reset: caches empty, write-back policy; the backing memory is then cleared
// one word a cycle, all MEMORY_WORDS words, during which no request is taken.
module two_level_fifo_cache_top #(
	parameter int FIRST_LEVEL_ENTRIES  = tfc_pkg::FLE_DEF,
	parameter int SECOND_LEVEL_ENTRIES = tfc_pkg::SLE_DEF,
	parameter int MEMORY_WORDS         = tfc_pkg::MW_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              write_policy,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              operation,
	input  logic [tfc_pkg::ADDR_W-1:0]        address,
	input  logic signed [tfc_pkg::DATA_W-1:0] write_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [tfc_pkg::DATA_W-1:0] read_data,
	output logic [tfc_pkg::LVL_W-1:0]         hit_level
);
	import tfc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	tfc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd)
	);

	tfc_dp #(
		.N1(FIRST_LEVEL_ENTRIES), .N2(SECOND_LEVEL_ENTRIES), .MW(MEMORY_WORDS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_valid && cfg_ready), .cfg_policy(write_policy),
		.operation(operation), .address(address), .write_data(write_data),
		.read_data(read_data), .hit_level(hit_level)
	);
endmodule

>>> hw/rtl/tfc_checker.sv
// Port-level checks for the two-level FIFO cache, bound to the top level.
// Depends on tfc_pkg.
module tfc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [tfc_pkg::DATA_W-1:0] read_data,
	input logic [tfc_pkg::LVL_W-1:0]         hit_level
);
	import tfc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(hit_level))
		else $error("result changed while stalled");

	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while one in flight");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("request taken while result pending");

	a_lvl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hit_level == LVL_L1 || hit_level == LVL_L2 || hit_level == LVL_MISS))
		else $error("bad hit level");
endmodule

bind two_level_fifo_cache_top tfc_checker u_chk (.*);
